// File: design/sudsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sudsp_pkg
// Shared types and constants for the SMS user data septet packer.
// ----------------------------------------------------------------------------
package sudsp_pkg;

   typedef enum logic [1:0] {
      MODE_OCTET  = 2'd0,
      MODE_SEPTET = 2'd1,
      MODE_WIDE   = 2'd2
   } mode_type;

   localparam mode_type MODE_RESET = MODE_SEPTET;

   localparam logic [7:0] LIMIT_OCTET  = 8'd140;
   localparam logic [7:0] LIMIT_SEPTET = 8'd160;
   localparam logic [7:0] LIMIT_UNITS  = 8'd70;
   localparam logic [6:0] SEPTET_MASK  = 7'h7F;
   localparam logic [2:0] SEPTET_BITS  = 3'd7;

   localparam int RESULT_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       run_last;
      logic       msg_end;
      logic       too_long;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

endpackage

// File: design/sudsp_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sudsp_encoder
// Message state and encoding logic; yields up to two result transactions per
// accepted input transaction.
// ----------------------------------------------------------------------------
module sudsp_encoder
   import sudsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data,
   input  logic       accept,
   input  logic [7:0] src_byte,
   input  logic       msg_last,
   output push_type   push
);

   mode_type   mode_ff;
   logic [6:0] bit_store_ff, bit_store_in;
   logic [2:0] bits_held_ff, bits_held_in;
   logic [7:0] unit_count_ff, unit_count_in;
   logic       discarding_ff, discarding_in;
   logic [7:0] pair_byte_ff, pair_byte_in;
   logic       pair_held_ff, pair_held_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_RESET;
         bit_store_ff  <= '0;
         bits_held_ff  <= '0;
         unit_count_ff <= '0;
         discarding_ff <= 1'b0;
         pair_byte_ff  <= '0;
         pair_held_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= mode_type'(csr_wr_data);
         end
         bit_store_ff  <= bit_store_in;
         bits_held_ff  <= bits_held_in;
         unit_count_ff <= unit_count_in;
         discarding_ff <= discarding_in;
         pair_byte_ff  <= pair_byte_in;
         pair_held_ff  <= pair_held_in;
      end
   end

   rsp_item_type error_item;
   assign error_item = '{packed_byte: 8'd0, run_last: 1'b1, msg_end: 1'b1, too_long: 1'b1};

   always_comb begin
      logic [13:0] acc;
      logic [2:0]  rem;
      logic [13:0] shifted;
      logic [6:0]  store_new;
      logic [2:0]  held_new;
      logic [14:0] flush_shift;
      logic [7:0]  first_byte;
      logic        have_first;
      logic        error;

      acc         = {bit_store_ff, src_byte[6:0] & SEPTET_MASK};
      rem         = bits_held_ff - 3'd1;
      shifted     = acc >> rem;
      have_first  = (bits_held_ff != 3'd0);
      if (have_first) begin
         store_new = acc[6:0] & (SEPTET_MASK >> (SEPTET_BITS - rem));
         held_new  = rem;
      end else begin
         store_new = src_byte[6:0];
         held_new  = SEPTET_BITS;
      end
      first_byte  = shifted[7:0];
      flush_shift = {8'd0, store_new} << (4'd8 - {1'b0, held_new});
      error       = 1'b0;

      bit_store_in  = bit_store_ff;
      bits_held_in  = bits_held_ff;
      unit_count_in = unit_count_ff;
      discarding_in = discarding_ff;
      pair_byte_in  = pair_byte_ff;
      pair_held_in  = pair_held_ff;
      push          = '0;

      if (accept) begin
         if (discarding_ff) begin
            if (msg_last) begin
               discarding_in = 1'b0;
            end
         end else begin
            unique case (mode_ff)
               MODE_OCTET: begin
                  if (unit_count_ff >= LIMIT_OCTET) begin
                     error = 1'b1;
                  end else begin
                     unit_count_in = unit_count_ff + 8'd1;
                     push.count    = 2'd1;
                     push.first    = '{packed_byte: src_byte, run_last: 1'b1,
                                       msg_end: msg_last, too_long: 1'b0};
                  end
               end
               MODE_SEPTET: begin
                  if (unit_count_ff >= LIMIT_SEPTET) begin
                     error = 1'b1;
                  end else begin
                     unit_count_in = unit_count_ff + 8'd1;
                     bit_store_in  = store_new;
                     bits_held_in  = held_new;
                     if (have_first) begin
                        push.count = 2'd1;
                        push.first = '{packed_byte: first_byte,
                                       run_last: !(msg_last && rem != 3'd0),
                                       msg_end: msg_last && rem == 3'd0,
                                       too_long: 1'b0};
                        if (msg_last && rem != 3'd0) begin
                           push.count  = 2'd2;
                           push.second = '{packed_byte: flush_shift[7:0], run_last: 1'b1,
                                           msg_end: 1'b1, too_long: 1'b0};
                        end
                     end else if (msg_last) begin
                        push.count = 2'd1;
                        push.first = '{packed_byte: flush_shift[7:0], run_last: 1'b1,
                                       msg_end: 1'b1, too_long: 1'b0};
                     end
                  end
               end
               MODE_WIDE: begin
                  if (!pair_held_ff) begin
                     if (!msg_last) begin
                        pair_byte_in = src_byte;
                        pair_held_in = 1'b1;
                     end
                  end else if (unit_count_ff >= LIMIT_UNITS) begin
                     error = 1'b1;
                  end else begin
                     unit_count_in = unit_count_ff + 8'd1;
                     pair_byte_in  = '0;
                     pair_held_in  = 1'b0;
                     push.count    = 2'd2;
                     push.first    = '{packed_byte: pair_byte_ff, run_last: 1'b0,
                                       msg_end: 1'b0, too_long: 1'b0};
                     push.second   = '{packed_byte: src_byte, run_last: 1'b1,
                                       msg_end: msg_last, too_long: 1'b0};
                  end
               end
               default: begin
                  error = 1'b1;
               end
            endcase
            if (error) begin
               push.count    = 2'd1;
               push.first    = error_item;
               push.second   = '0;
               discarding_in = !msg_last;
            end
         end
         if (msg_last || error) begin
            bit_store_in  = '0;
            bits_held_in  = '0;
            unit_count_in = '0;
            pair_byte_in  = '0;
            pair_held_in  = 1'b0;
         end
      end
   end

endmodule

// File: design/sudsp_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sudsp_result_fifo
// Result queue: takes up to two results per cycle, gives one unless stalled.
// ----------------------------------------------------------------------------
module sudsp_result_fifo
   import sudsp_pkg::*;
#(
   parameter int DEPTH = RESULT_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       space_ok,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_packed_byte,
   output logic       rsp_run_last,
   output logic       rsp_msg_end,
   output logic       rsp_too_long
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_next;
   logic             pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] result;
      if (ptr == PTR_W'(DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + PTR_W'(1);
      end
      return result;
   endfunction

   assign wr_next   = ptr_inc(wr_ptr_ff);
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign space_ok  = (count_ff <= CNT_W'(DEPTH - 2));

   assign rsp_packed_byte = entry_ff[rd_ptr_ff].packed_byte;
   assign rsp_run_last    = entry_ff[rd_ptr_ff].run_last;
   assign rsp_msg_end     = entry_ff[rd_ptr_ff].msg_end;
   assign rsp_too_long    = entry_ff[rd_ptr_ff].too_long;

   always_comb begin
      unique case (push.count)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = ptr_inc(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

// File: design/sms_user_data_septet_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_user_data_septet_packer
// SMS user data encoder: octet pass-through, seven-bit packing or sixteen-bit
// pass-through, with message length limits and discard of over-long messages.
//
//   channel  direction  handshake           payload
//   req_     in         req_valid/req_stall src_byte, msg_last
//   rsp_     out        rsp_valid/rsp_stall packed_byte, run_last, msg_end,
//                                           too_long
//   csr_     in         csr_wr_en           csr_wr_data (encoding mode)
//
// One request transaction per cycle while req_stall is low; its results
// enter the result queue at the same edge and leave one per cycle while
// rsp_stall is low, so the single response port sets the sustained rate.
// Requests stall while the queue lacks room for two results.
// Reset is synchronous; mode returns to seven-bit packing.
// ----------------------------------------------------------------------------
module sms_user_data_septet_packer
   import sudsp_pkg::*;
#(
   parameter int RESULT_DEPTH = RESULT_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_src_byte,
   input  logic       req_msg_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_packed_byte,
   output logic       rsp_run_last,
   output logic       rsp_msg_end,
   output logic       rsp_too_long
);

   push_type push;
   logic     space_ok;
   logic     accept;

   assign req_stall = !space_ok;
   assign accept    = req_valid && space_ok;

   sudsp_encoder u_encoder (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .src_byte    (req_src_byte),
      .msg_last    (req_msg_last),
      .push        (push)
   );

   sudsp_result_fifo #(
      .DEPTH (RESULT_DEPTH)
   ) u_result_fifo (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .space_ok        (space_ok),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_msg_end     (rsp_msg_end),
      .rsp_too_long    (rsp_too_long)
   );

endmodule
